// File: rtl/core/gprdz_pkg.sv
`timescale 1ns / 1ps
package gprdz_pkg;

   localparam int SAMPLE_BITS = 16;

   localparam int AXIS_W   = 16;
   localparam int TRIG_W   = 16;
   localparam int DZ_W     = 15;
   localparam int BTN_W    = 16;
   localparam int TOUT_W   = 8;
   localparam int RKEY_W   = 10;
   localparam int LKEY_W   = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int M2_W    = 2 * AXIS_W;
   localparam int FRAC_X  = 16;
   localparam int RAD_W   = M2_W + FRAC_X;
   localparam int ROOT_W  = RAD_W / 2;
   localparam int DSC_W   = DZ_W + 1;
   localparam int PROD_W  = AXIS_W + ROOT_W;
   localparam int DEN_W   = DSC_W + ROOT_W;
   localparam int NUM_W   = PROD_W + SAMPLE_BITS - 1;
   localparam int Q_W     = SAMPLE_BITS;
   localparam int DIV_W   = DEN_W + Q_W;
   localparam int EXT_W   = Q_W + AXIS_W;
   localparam int DZ_SHIFT = 8;

   localparam logic [Q_W-1:0]   FULL_SCALE = Q_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
   localparam logic [DSC_W-1:0] ONE_Q15    = DSC_W'(1 << DZ_W);

   localparam int LANE_LAT = ROOT_W + Q_W + 7;

   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [TRIG_W-1:0]     TRIG_DZ_RESET = TRIG_W'(6554);
   localparam logic [DZ_W-1:0]       STICK_DZ_RESET = DZ_W'(4915);
   localparam logic [TOUT_W-1:0]     TRIG_FULL = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TRIG_DZ  = 2'd0,
      CSR_STICK_DZ = 2'd1,
      CSR_RS_EN    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                     ok;
      logic [BTN_W-1:0]         buttons;
      logic [TOUT_W-1:0]        rtrig;
      logic [TOUT_W-1:0]        ltrig;
   } side_type;

   typedef struct packed {
      side_type                 side;
      logic signed [AXIS_W-1:0] lx;
      logic signed [AXIS_W-1:0] ly;
      logic signed [AXIS_W-1:0] rx;
      logic signed [AXIS_W-1:0] ry;
      logic                     lzero;
      logic                     rzero;
   } item_type;

   typedef struct packed {
      logic              xn;
      logic              yn;
      logic              zero;
      logic [AXIS_W-1:0] ax;
      logic [AXIS_W-1:0] ay;
      logic [DZ_W-1:0]   dz;
   } carry_type;

   typedef struct packed {
      logic xn;
      logic yn;
      logic zero;
      logic ovfx;
      logic ovfy;
   } dcarry_type;

endpackage

// File: rtl/core/gprdz_front.sv
`timescale 1ns / 1ps
module gprdz_front import gprdz_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic                     frame_valid,
   input  logic [TRIG_W-1:0]        right_trigger,
   input  logic [TRIG_W-1:0]        left_trigger,
   input  logic [RKEY_W-1:0]        right_keys,
   input  logic [LKEY_W-1:0]        left_keys,
   input  logic signed [AXIS_W-1:0] left_x,
   input  logic signed [AXIS_W-1:0] left_y,
   input  logic signed [AXIS_W-1:0] right_x,
   input  logic signed [AXIS_W-1:0] right_y,
   input  logic [TRIG_W-1:0]        trig_dz,
   input  logic                     rs_en,
   input  logic                     push_ready,
   output logic                     push_valid,
   output item_type                 push_item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     load;

   assign in_ready   = !valid_ff || push_ready;
   assign load       = in_valid && in_ready;
   assign push_valid = valid_ff;
   assign push_item  = item_ff;

   always_comb begin
      item_in = '0;
      item_in.lzero = 1'b1;
      item_in.rzero = 1'b1;
      if (frame_valid) begin
         item_in.side.ok = 1'b1;
         item_in.side.rtrig = (right_trigger > trig_dz) ? TRIG_FULL : '0;
         item_in.side.ltrig = (left_trigger > trig_dz) ? TRIG_FULL : '0;
         item_in.side.buttons = {right_keys[5], right_keys[4], right_keys[3], right_keys[2],
                                 2'b00, right_keys[0], left_keys[0],
                                 right_keys[1], left_keys[1], 2'b00,
                                 right_keys[9] | left_keys[5], right_keys[8] | left_keys[4],
                                 right_keys[7] | left_keys[3], right_keys[6] | left_keys[2]};
         item_in.lx = left_x;
         item_in.ly = left_y;
         item_in.rx = right_x;
         item_in.ry = right_y;
         item_in.lzero = 1'b0;
         item_in.rzero = !rs_en;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

endmodule

// File: rtl/core/gprdz_fifo.sv
`timescale 1ns / 1ps
module gprdz_fifo import gprdz_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     not_full,
   input  logic     pop,
   output logic     not_empty,
   output item_type head
);

   item_type                mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [FIFO_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                    do_push, do_pop;

   assign not_full  = cnt_ff != FIFO_CNT_W'(FIFO_DEPTH);
   assign not_empty = cnt_ff != '0;
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;
   assign head      = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule

// File: rtl/core/gprdz_stick.sv
`timescale 1ns / 1ps
module gprdz_stick import gprdz_pkg::*; (
   input  logic                     clock,
   input  logic                     en,
   input  logic signed [AXIS_W-1:0] x,
   input  logic signed [AXIS_W-1:0] y,
   input  logic                     force_zero,
   input  logic [DZ_W-1:0]          dz,
   output logic signed [AXIS_W-1:0] out_x,
   output logic signed [AXIS_W-1:0] out_y
);

   // squares
   carry_type          c1_ff;
   logic [M2_W-1:0]    xx_ff, yy_ff;
   logic [2*DZ_W-1:0]  dd_ff;
   logic [AXIS_W-1:0]  ax_c, ay_c;
   logic [M2_W-1:0]    m2_c;

   assign ax_c = x[AXIS_W-1] ? (~x + 1'b1) : x;
   assign ay_c = y[AXIS_W-1] ? (~y + 1'b1) : y;
   assign m2_c = xx_ff + yy_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff.xn   <= x[AXIS_W-1];
         c1_ff.yn   <= y[AXIS_W-1];
         c1_ff.zero <= force_zero;
         c1_ff.ax   <= ax_c;
         c1_ff.ay   <= ay_c;
         c1_ff.dz   <= dz;
         xx_ff <= ax_c * ax_c;
         yy_ff <= ay_c * ay_c;
         dd_ff <= dz * dz;
      end
   end

   // square root, one result bit per stage
   carry_type          sc_ff   [ROOT_W+1];
   logic [RAD_W-1:0]   rem_ff  [ROOT_W+1];
   logic [ROOT_W-1:0]  root_ff [ROOT_W+1];
   carry_type          sc0_c;

   always_comb begin
      sc0_c      = c1_ff;
      sc0_c.zero = c1_ff.zero || (m2_c < M2_W'(dd_ff));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sc_ff[0]      <= sc0_c;
         rem_ff[0]     <= {m2_c, FRAC_X'(0)};
         root_ff[0]    <= '0;
      end
   end

   for (genvar s = 0; s < ROOT_W; s++) begin : g_sqrt
      localparam int K = ROOT_W - 1 - s;
      logic [RAD_W-1:0] trial;
      assign trial = (RAD_W'(root_ff[s]) << (K + 1)) | (RAD_W'(1) << (2 * K));
      always_ff @(posedge clock) begin
         if (en) begin
            sc_ff[s+1] <= sc_ff[s];
            if (rem_ff[s] >= trial) begin
               rem_ff[s+1]  <= rem_ff[s] - trial;
               root_ff[s+1] <= root_ff[s] | (ROOT_W'(1) << K);
            end else begin
               rem_ff[s+1]  <= rem_ff[s];
               root_ff[s+1] <= root_ff[s];
            end
         end
      end
   end

   // numerator term, denominator scale
   carry_type          cn_ff;
   logic [ROOT_W-1:0]  num_ff, rootn_ff;
   logic [DSC_W-1:0]   dsc_ff;
   carry_type          cn_c;

   always_comb begin
      cn_c      = sc_ff[ROOT_W];
      cn_c.zero = sc_ff[ROOT_W].zero || (root_ff[ROOT_W] == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cn_ff      <= cn_c;
         num_ff     <= root_ff[ROOT_W] - (ROOT_W'(sc_ff[ROOT_W].dz) << DZ_SHIFT);
         rootn_ff   <= root_ff[ROOT_W];
         dsc_ff     <= ONE_Q15 - DSC_W'(sc_ff[ROOT_W].dz);
      end
   end

   // products
   dcarry_type         cm_ff, cf_ff;
   logic [PROD_W-1:0]  px_ff, py_ff;
   logic [DEN_W-1:0]   denm_ff, denf_ff;
   logic [NUM_W-1:0]   nx_ff, ny_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         cm_ff   <= '{xn: cn_ff.xn, yn: cn_ff.yn, zero: cn_ff.zero, ovfx: 1'b0, ovfy: 1'b0};
         px_ff   <= cn_ff.ax * num_ff;
         py_ff   <= cn_ff.ay * num_ff;
         denm_ff <= dsc_ff * rootn_ff;
         cf_ff   <= cm_ff;
         nx_ff   <= (NUM_W'(px_ff) << (SAMPLE_BITS - 1)) - NUM_W'(px_ff);
         ny_ff   <= (NUM_W'(py_ff) << (SAMPLE_BITS - 1)) - NUM_W'(py_ff);
         denf_ff <= denm_ff;
      end
   end

   // restoring division, one quotient bit per stage
   dcarry_type         dc_ff  [Q_W+1];
   logic [DIV_W-1:0]   rx_ff  [Q_W+1];
   logic [DIV_W-1:0]   ry_ff  [Q_W+1];
   logic [Q_W-1:0]     qx_ff  [Q_W+1];
   logic [Q_W-1:0]     qy_ff  [Q_W+1];
   logic [DEN_W-1:0]   den_ff [Q_W+1];
   logic [DIV_W-1:0]   den_top;
   dcarry_type         dc0_c;

   assign den_top = DIV_W'(denf_ff) << Q_W;

   always_comb begin
      dc0_c      = cf_ff;
      dc0_c.ovfx = DIV_W'(nx_ff) >= den_top;
      dc0_c.ovfy = DIV_W'(ny_ff) >= den_top;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dc_ff[0]      <= dc0_c;
         rx_ff[0]      <= DIV_W'(nx_ff);
         ry_ff[0]      <= DIV_W'(ny_ff);
         qx_ff[0]      <= '0;
         qy_ff[0]      <= '0;
         den_ff[0]     <= denf_ff;
      end
   end

   for (genvar t = 0; t < Q_W; t++) begin : g_div
      localparam int J = Q_W - 1 - t;
      logic [DIV_W-1:0] sub;
      assign sub = DIV_W'(den_ff[t]) << J;
      always_ff @(posedge clock) begin
         if (en) begin
            dc_ff[t+1]  <= dc_ff[t];
            den_ff[t+1] <= den_ff[t];
            if (rx_ff[t] >= sub) begin
               rx_ff[t+1] <= rx_ff[t] - sub;
               qx_ff[t+1] <= qx_ff[t] | (Q_W'(1) << J);
            end else begin
               rx_ff[t+1] <= rx_ff[t];
               qx_ff[t+1] <= qx_ff[t];
            end
            if (ry_ff[t] >= sub) begin
               ry_ff[t+1] <= ry_ff[t] - sub;
               qy_ff[t+1] <= qy_ff[t] | (Q_W'(1) << J);
            end else begin
               ry_ff[t+1] <= ry_ff[t];
               qy_ff[t+1] <= qy_ff[t];
            end
         end
      end
   end

   // saturate, sign, truncate
   logic [Q_W-1:0]    magx, magy;
   logic [EXT_W-1:0]  ex, ey;
   logic [AXIS_W-1:0] ox_ff, oy_ff;

   always_comb begin
      magx = (dc_ff[Q_W].ovfx || qx_ff[Q_W] > FULL_SCALE) ? FULL_SCALE : qx_ff[Q_W];
      magy = (dc_ff[Q_W].ovfy || qy_ff[Q_W] > FULL_SCALE) ? FULL_SCALE : qy_ff[Q_W];
      ex = dc_ff[Q_W].xn ? (EXT_W'(0) - EXT_W'(magx)) : EXT_W'(magx);
      ey = dc_ff[Q_W].yn ? (EXT_W'(0) - EXT_W'(magy)) : EXT_W'(magy);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ox_ff <= dc_ff[Q_W].zero ? '0 : ex[AXIS_W-1:0];
         oy_ff <= dc_ff[Q_W].zero ? '0 : ey[AXIS_W-1:0];
      end
   end

   assign out_x = ox_ff;
   assign out_y = oy_ff;

endmodule

// File: rtl/core/gamepad_radial_deadzone_mapper.sv
`timescale 1ns / 1ps
// Builds one gamepad report per controller frame: trigger thresholds, button mapping and a
// radial deadzone with rescale on the left stick and, when enabled, the right stick. One
// frame is taken per clock in steady flow. Each stick lane holds a 24-stage square root
// and a SAMPLE_BITS-stage divider. A two-entry queue sits between the input register and
// the stick pipeline, and the pipeline holds as a whole while a report waits on rsp_ready.
// The user must write registers through csr_index / csr_data (0 trigger deadzone, 1 stick
// deadzone, 2 right stick enable) only while idle; the block itself does not enforce this.
module gamepad_radial_deadzone_mapper import gprdz_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_frame_valid,
   input  logic [TRIG_W-1:0]        req_right_trigger,
   input  logic [TRIG_W-1:0]        req_left_trigger,
   input  logic [RKEY_W-1:0]        req_right_keys,
   input  logic [LKEY_W-1:0]        req_left_keys,
   input  logic signed [AXIS_W-1:0] req_left_x,
   input  logic signed [AXIS_W-1:0] req_left_y,
   input  logic signed [AXIS_W-1:0] req_right_x,
   input  logic signed [AXIS_W-1:0] req_right_y,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_ok,
   output logic [BTN_W-1:0]         rsp_buttons,
   output logic [TOUT_W-1:0]        rsp_right_trigger_out,
   output logic [TOUT_W-1:0]        rsp_left_trigger_out,
   output logic signed [AXIS_W-1:0] rsp_thumb_lx,
   output logic signed [AXIS_W-1:0] rsp_thumb_ly,
   output logic signed [AXIS_W-1:0] rsp_thumb_rx,
   output logic signed [AXIS_W-1:0] rsp_thumb_ry
);

   logic [TRIG_W-1:0] trig_dz_ff;
   logic [DZ_W-1:0]   stick_dz_ff;
   logic              rs_en_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         trig_dz_ff  <= TRIG_DZ_RESET;
         stick_dz_ff <= STICK_DZ_RESET;
         rs_en_ff    <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_TRIG_DZ:  trig_dz_ff  <= csr_data[TRIG_W-1:0];
            CSR_STICK_DZ: stick_dz_ff <= csr_data[DZ_W-1:0];
            CSR_RS_EN:    rs_en_ff    <= csr_data[0];
            default:      ;
         endcase
      end
   end

   logic     push_valid, fifo_not_full, fifo_not_empty, en;
   item_type push_item, head;

   gprdz_front u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .frame_valid   (req_frame_valid),
      .right_trigger (req_right_trigger),
      .left_trigger  (req_left_trigger),
      .right_keys    (req_right_keys),
      .left_keys     (req_left_keys),
      .left_x        (req_left_x),
      .left_y        (req_left_y),
      .right_x       (req_right_x),
      .right_y       (req_right_y),
      .trig_dz       (trig_dz_ff),
      .rs_en         (rs_en_ff),
      .push_ready    (fifo_not_full),
      .push_valid    (push_valid),
      .push_item     (push_item)
   );

   gprdz_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_item (push_item),
      .not_full  (fifo_not_full),
      .pop       (en),
      .not_empty (fifo_not_empty),
      .head      (head)
   );

   side_type sb_ff  [LANE_LAT];
   logic     sbv_ff [LANE_LAT];

   assign en = !sbv_ff[LANE_LAT-1] || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANE_LAT; i++) begin
            sbv_ff[i] <= 1'b0;
         end
      end else if (en) begin
         sbv_ff[0] <= fifo_not_empty;
         for (int i = 1; i < LANE_LAT; i++) begin
            sbv_ff[i] <= sbv_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sb_ff[0] <= head.side;
         for (int i = 1; i < LANE_LAT; i++) begin
            sb_ff[i] <= sb_ff[i-1];
         end
      end
   end

   gprdz_stick u_left (
      .clock      (clock),
      .en         (en),
      .x          (head.lx),
      .y          (head.ly),
      .force_zero (head.lzero),
      .dz         (stick_dz_ff),
      .out_x      (rsp_thumb_lx),
      .out_y      (rsp_thumb_ly)
   );

   gprdz_stick u_right (
      .clock      (clock),
      .en         (en),
      .x          (head.rx),
      .y          (head.ry),
      .force_zero (head.rzero),
      .dz         (stick_dz_ff),
      .out_x      (rsp_thumb_rx),
      .out_y      (rsp_thumb_ry)
   );

   assign rsp_valid             = sbv_ff[LANE_LAT-1];
   assign rsp_ok                = sb_ff[LANE_LAT-1].ok;
   assign rsp_buttons           = sb_ff[LANE_LAT-1].buttons;
   assign rsp_right_trigger_out = sb_ff[LANE_LAT-1].rtrig;
   assign rsp_left_trigger_out  = sb_ff[LANE_LAT-1].ltrig;

endmodule

// File: rtl/core/gprdz_checker.sv
`timescale 1ns / 1ps
module gprdz_checker import gprdz_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic                     rsp_ok,
   input logic [BTN_W-1:0]         rsp_buttons,
   input logic [TOUT_W-1:0]        rsp_right_trigger_out,
   input logic [TOUT_W-1:0]        rsp_left_trigger_out,
   input logic signed [AXIS_W-1:0] rsp_thumb_lx,
   input logic signed [AXIS_W-1:0] rsp_thumb_ly,
   input logic signed [AXIS_W-1:0] rsp_thumb_rx,
   input logic signed [AXIS_W-1:0] rsp_thumb_ry
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_buttons) && $stable(rsp_thumb_lx))
      else $error("report dropped while stalled");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_buttons == '0 && rsp_right_trigger_out == '0 &&
         rsp_left_trigger_out == '0 && rsp_thumb_lx == '0 && rsp_thumb_ly == '0 &&
         rsp_thumb_rx == '0 && rsp_thumb_ry == '0)
      else $error("invalid frame with non-zero report");

   a_trig: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_right_trigger_out == '0 || rsp_right_trigger_out == TRIG_FULL) &&
         (rsp_left_trigger_out == '0 || rsp_left_trigger_out == TRIG_FULL))
      else $error("trigger byte not 0 or full");

   a_unused_btn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_buttons[11:10] == 2'b00 && rsp_buttons[5:4] == 2'b00)
      else $error("unmapped button bit set");

endmodule

bind gamepad_radial_deadzone_mapper gprdz_checker u_gprdz_checker (.*);

// File: tb/tb_gamepad_radial_deadzone_mapper.sv
`timescale 1ns / 1ps
module tb_gamepad_radial_deadzone_mapper;
   import gprdz_pkg::*;

   typedef struct {
      logic              frame_valid;
      logic [15:0]       rtrig;
      logic [15:0]       ltrig;
      logic [9:0]        rkeys;
      logic [5:0]        lkeys;
      logic signed [15:0] lx, ly, rx, ry;
   } frame_type;

   typedef struct {
      logic        ok;
      logic [15:0] buttons;
      logic [7:0]  rtrig_out;
      logic [7:0]  ltrig_out;
      logic [15:0] lx, ly, rx, ry;
   } report_type;

   class report_scoreboard;
      logic [15:0] trig_dz;
      logic [14:0] stick_dz;
      logic        rs_en;
      report_type  pending[$];
      int          errors;
      int          checked;

      function new();
         trig_dz = 16'd6554; stick_dz = 15'd4915; rs_en = 1'b0;
         errors = 0; checked = 0;
      endfunction

      function automatic longint unsigned isqrt(longint unsigned v);
         longint unsigned r, b;
         r = 0; b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v -= r + b; r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      function automatic logic [15:0] axis(logic neg, longint unsigned mag,
                                           longint unsigned num, longint unsigned den);
         longint unsigned q;
         q = (mag * num * 64'd32767) / den;
         if (q > 32767) q = 32767;
         if (neg) q = -q;
         return q[15:0];
      endfunction

      function automatic void rescale(logic [15:0] x, logic [15:0] y,
                                      output logic [15:0] ox, output logic [15:0] oy);
         longint unsigned ax, ay, d, m2, r, num, den;
         ax = x[15] ? 64'h10000 - x : x;
         ay = y[15] ? 64'h10000 - y : y;
         d = stick_dz;
         m2 = ax * ax + ay * ay;
         ox = 0; oy = 0;
         if (m2 < d * d) return;
         r = isqrt(m2 << 16);
         if (r == 0) return;
         num = r - (d << 8);
         den = (64'd32768 - d) * r;
         ox = axis(x[15], ax, num, den);
         oy = axis(y[15], ay, num, den);
      endfunction

      function void note_frame(frame_type f);
         report_type e;
         logic [15:0] b;
         e = '{default: 0};
         if (f.frame_valid) begin
            e.ok = 1;
            e.rtrig_out = (f.rtrig > trig_dz) ? 8'd255 : 8'd0;
            e.ltrig_out = (f.ltrig > trig_dz) ? 8'd255 : 8'd0;
            b = 0;
            b[9] = f.rkeys[0]; b[8] = f.lkeys[0];
            b[7] = f.rkeys[1]; b[6] = f.lkeys[1];
            b[12] = f.rkeys[2]; b[13] = f.rkeys[3];
            b[14] = f.rkeys[4]; b[15] = f.rkeys[5];
            b[0] = f.rkeys[6] | f.lkeys[2];
            b[1] = f.rkeys[7] | f.lkeys[3];
            b[2] = f.rkeys[8] | f.lkeys[4];
            b[3] = f.rkeys[9] | f.lkeys[5];
            e.buttons = b;
            rescale(f.lx, f.ly, e.lx, e.ly);
            if (rs_en) rescale(f.rx, f.ry, e.rx, e.ry);
         end
         pending.push_back(e);
      endfunction

      function void check_report(report_type a);
         report_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected report", $time);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (a.ok !== e.ok) begin
            $display("%0t: ok exp %0d got %0d", $time, e.ok, a.ok); errors++;
         end
         if (a.buttons !== e.buttons) begin
            $display("%0t: buttons exp %h got %h", $time, e.buttons, a.buttons); errors++;
         end
         if (a.rtrig_out !== e.rtrig_out) begin
            $display("%0t: rtrig exp %0d got %0d", $time, e.rtrig_out, a.rtrig_out); errors++;
         end
         if (a.ltrig_out !== e.ltrig_out) begin
            $display("%0t: ltrig exp %0d got %0d", $time, e.ltrig_out, a.ltrig_out); errors++;
         end
         if (a.lx !== e.lx) begin
            $display("%0t: lx exp %h got %h", $time, e.lx, a.lx); errors++;
         end
         if (a.ly !== e.ly) begin
            $display("%0t: ly exp %h got %h", $time, e.ly, a.ly); errors++;
         end
         if (a.rx !== e.rx) begin
            $display("%0t: rx exp %h got %h", $time, e.rx, a.rx); errors++;
         end
         if (a.ry !== e.ry) begin
            $display("%0t: ry exp %h got %h", $time, e.ry, a.ry); errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic csr_valid = 0, csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = 0;
   logic [CSR_DATA_W-1:0] csr_data = 0;
   logic req_valid = 0, req_ready;
   logic req_frame_valid = 0;
   logic [TRIG_W-1:0] req_right_trigger = 0, req_left_trigger = 0;
   logic [RKEY_W-1:0] req_right_keys = 0;
   logic [LKEY_W-1:0] req_left_keys = 0;
   logic signed [AXIS_W-1:0] req_left_x = 0, req_left_y = 0, req_right_x = 0, req_right_y = 0;
   logic rsp_valid, rsp_ready = 0, rsp_ok;
   logic [BTN_W-1:0] rsp_buttons;
   logic [TOUT_W-1:0] rsp_right_trigger_out, rsp_left_trigger_out;
   logic signed [AXIS_W-1:0] rsp_thumb_lx, rsp_thumb_ly, rsp_thumb_rx, rsp_thumb_ry;

   gamepad_radial_deadzone_mapper dut (.*);

   report_scoreboard sb;
   int  send_idle = 0, recv_idle = 0;
   bit  hold_rsp = 0;
   int  quiet = 0;
   int  sent = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      report_type a;
      if (!reset && rsp_valid && rsp_ready) begin
         a.ok = rsp_ok; a.buttons = rsp_buttons;
         a.rtrig_out = rsp_right_trigger_out; a.ltrig_out = rsp_left_trigger_out;
         a.lx = rsp_thumb_lx; a.ly = rsp_thumb_ly;
         a.rx = rsp_thumb_rx; a.ry = rsp_thumb_ry;
         sb.check_report(a);
      end
      if (reset) rsp_ready <= 0;
      else rsp_ready <= !hold_rsp && ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet > 20000) begin
         $display("tb: failure");
         $finish;
      end
   end

   // valid stays high between back-to-back transactions; it drops only to idle
   task automatic send_frame(frame_type f);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
      req_valid <= 1;
      req_frame_valid <= f.frame_valid;
      req_right_trigger <= f.rtrig; req_left_trigger <= f.ltrig;
      req_right_keys <= f.rkeys; req_left_keys <= f.lkeys;
      req_left_x <= f.lx; req_left_y <= f.ly;
      req_right_x <= f.rx; req_right_y <= f.ry;
      do @(posedge clock); while (!req_ready);
      sb.note_frame(f);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [15:0] val);
      csr_valid <= 1; csr_index <= idx; csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      case (idx)
         CSR_TRIG_DZ:  sb.trig_dz = val;
         CSR_STICK_DZ: sb.stick_dz = val[14:0];
         CSR_RS_EN:    sb.rs_en = val[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic logic signed [15:0] stick_val();
      case ($urandom_range(5))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return $signed(16'($urandom_range(0, 2000)) - 16'd1000);
         default: return $signed(16'($urandom));
      endcase
   endfunction

   function automatic frame_type rand_frame();
      frame_type f;
      f.frame_valid = ($urandom_range(9) != 0);
      f.rtrig = 16'($urandom); f.ltrig = 16'($urandom);
      f.rkeys = 10'($urandom); f.lkeys = 6'($urandom);
      f.lx = stick_val(); f.ly = stick_val();
      f.rx = stick_val(); f.ry = stick_val();
      return f;
   endfunction

   task automatic run_random(int n);
      repeat (n) send_frame(rand_frame());
   endtask

   initial begin
      frame_type f;
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: defaults first
      f = '{1, 16'd6555, 16'd6554, 10'h3FF, 6'h3F, 16'sh7FFF, 16'sh7FFF, 0, 0};
      send_frame(f);
      f = '{0, 16'hFFFF, 16'hFFFF, 10'h3FF, 6'h3F, 16'sh7FFF, 0, 0, 0};
      send_frame(f);
      f = '{1, 0, 16'hFFFF, 10'h0, 6'h0, 16'sh8000, 16'sh8000, 16'sh7FFF, 0};
      send_frame(f);
      f = '{1, 16'hFFFF, 0, 10'h155, 6'h2A, 16'sd4914, 0, 0, 0};
      send_frame(f);
      f = '{1, 16'd6554, 16'd6555, 10'h2AA, 6'h15, 16'sd4915, 0, 0, 0};
      send_frame(f);
      f = '{1, 0, 0, 10'h0, 6'h0, -16'sd3476, 16'sd3476, 0, 0};
      send_frame(f);
      drain();
      write_reg(CSR_STICK_DZ, 16'd0);
      write_reg(CSR_RS_EN, 16'd1);
      write_reg(CSR_TRIG_DZ, 16'd0);
      f = '{1, 0, 16'd1, 0, 0, 0, 0, 0, 0};
      send_frame(f);
      f = '{1, 16'd1, 0, 0, 0, 16'sd1, -16'sd1, 16'sh8000, 16'sh7FFF};
      send_frame(f);
      f = '{1, 0, 0, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
      send_frame(f);
      drain();
      write_reg(CSR_STICK_DZ, 16'h7FFF);
      write_reg(CSR_TRIG_DZ, 16'hFFFF);
      f = '{1, 16'hFFFF, 16'hFFFF, 0, 0, 16'sh7FFF, 0, 16'sh8000, 16'sh8000};
      send_frame(f);
      f = '{1, 0, 0, 0, 0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFE, 0};
      send_frame(f);
      drain();

      write_reg(CSR_TRIG_DZ, 16'd6554);
      write_reg(CSR_STICK_DZ, 16'd4915);
      write_reg(CSR_RS_EN, 16'd0);
      send_idle = 12; recv_idle = 78;
      run_random(200);
      drain();

      write_reg(CSR_TRIG_DZ, 16'($urandom));
      write_reg(CSR_STICK_DZ, 16'($urandom_range(0, 32767)));
      write_reg(CSR_RS_EN, 16'd1);
      send_idle = 78; recv_idle = 12;
      run_random(200);
      drain();

      write_reg(CSR_STICK_DZ, 16'($urandom_range(0, 12000)));
      send_idle = 0; recv_idle = 0;
      hold_rsp = 1;
      fork
         begin
            repeat (150) @(posedge clock);
            hold_rsp = 0;
         end
         run_random(100);
      join
      run_random(100);
      drain();

      $display("tb: %0d frames sent, %0d reports checked, deadzone and idle settings varied",
               sent, sb.checked);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule

// File: sim.f
rtl/core/gprdz_pkg.sv
rtl/core/gprdz_front.sv
rtl/core/gprdz_fifo.sv
rtl/core/gprdz_stick.sv
rtl/core/gamepad_radial_deadzone_mapper.sv
rtl/core/gprdz_checker.sv
tb/tb_gamepad_radial_deadzone_mapper.sv
